@@ rtl/trsm_pkg.sv @@
// package for the three-wire serial master
// beat payload types, op codes and fixed protocol constants; no dependencies
package trsm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BURST = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [7:0] BURST_CMD   = 8'hBF;
    localparam logic [2:0] WEEKDAY_IDX = 3'd5;

    typedef struct packed {
        logic       start_req;
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       dat_in;
    } in_t;

    typedef struct packed {
        logic       ce_pin;
        logic       clk_pin;
        logic       dat_out;
        logic       dat_drive;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [2:0] byte_index;
        logic       last_byte;
    } out_t;

endpackage

@@ rtl/three_wire_rtc_serial_master.sv @@
// three-wire serial link master (chip enable, clock, bidirectional data)
// one input beat is one half-bit tick; depends on trsm_pkg
//
//   channel | ports                    | payload
//   --------+--------------------------+---------------------------
//   input   | s_valid, s_ready, s_data | trsm_pkg::in_t, one tick
//   result  | m_valid, m_ready, m_data | trsm_pkg::out_t, one per tick
//
// for every tick, next state and pin levels come from the state
// registers and the tick in one pass, and land in the result register.
// a new tick is taken each cycle while the result register is empty or drained.
// reset (aresetn low, synchronous) returns the link to idle and empties the result.
// a stalled result holds s_ready low until it is taken.
module three_wire_rtc_serial_master #(
    parameter int BURST_BYTES = 7
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  trsm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output trsm_pkg::out_t m_data
);
    import trsm_pkg::*;

    localparam logic [2:0] LAST_IDX = 3'(BURST_BYTES - 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_WDATA = 3'd2,
        PH_READ  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       clock_half_reg, clock_half_next;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] byte_count_reg, byte_count_next;
    logic [1:0] held_op_reg, held_op_next;
    logic [7:0] held_data_reg, held_data_next;
    logic       m_valid_reg;
    out_t       m_data_reg;
    out_t       res;
    logic       acc;
    logic [7:0] rx;
    logic [7:0] bcd_bin;
    logic       burst;
    logic       last;
    logic [7:0] load;

    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign rx      = shift_reg | (8'(s_data.dat_in) << bit_count_reg);
    assign bcd_bin = 8'({rx[7:4], 3'b000}) + 8'({rx[7:4], 1'b0}) + 8'(rx[3:0]);
    assign burst   = (held_op_reg == OP_BURST);
    assign last    = !burst || (byte_count_reg >= LAST_IDX);
    assign load    = (s_data.op == OP_BURST) ? BURST_CMD : s_data.reg_addr;

    always_comb begin
        phase_next      = phase_reg;
        clock_half_next = clock_half_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        byte_count_next = byte_count_reg;
        held_op_next    = held_op_reg;
        held_data_next  = held_data_reg;
        res             = '0;
        case (phase_reg)
            PH_ADDR, PH_WDATA: begin
                res.ce_pin    = 1'b1;
                res.dat_out   = shift_reg[0];
                res.dat_drive = 1'b1;
                res.busy_res  = 1'b1;
                res.clk_pin   = clock_half_reg;
                if (!clock_half_reg) begin
                    clock_half_next = 1'b1;
                end else begin
                    clock_half_next = 1'b0;
                    shift_next      = {1'b0, shift_reg[7:1]};
                    if (bit_count_reg == 3'd7) begin
                        bit_count_next = '0;
                        if (phase_reg == PH_WDATA) begin
                            phase_next = PH_DONE;
                        end else if (held_op_reg == OP_WRITE) begin
                            phase_next = PH_WDATA;
                            shift_next = held_data_reg;
                        end else begin
                            phase_next      = PH_READ;
                            shift_next      = '0;
                            byte_count_next = '0;
                        end
                    end else begin
                        bit_count_next = bit_count_reg + 3'd1;
                    end
                end
            end
            PH_READ: begin
                res.ce_pin   = 1'b1;
                res.busy_res = 1'b1;
                if (!clock_half_reg) begin
                    clock_half_next = 1'b1;
                end else begin
                    res.clk_pin     = 1'b1;
                    clock_half_next = 1'b0;
                    if (bit_count_reg == 3'd7) begin
                        res.byte_valid = 1'b1;
                        res.byte_value = (burst && byte_count_reg != WEEKDAY_IDX) ?
                                         bcd_bin : rx;
                        res.byte_index = burst ? byte_count_reg : 3'd0;
                        res.last_byte  = last;
                        shift_next     = '0;
                        bit_count_next = '0;
                        if (last) begin
                            phase_next = PH_DONE;
                        end else begin
                            byte_count_next = byte_count_reg + 3'd1;
                        end
                    end else begin
                        shift_next     = rx;
                        bit_count_next = bit_count_reg + 3'd1;
                    end
                end
            end
            PH_DONE: begin
                res.busy_res    = 1'b1;
                clock_half_next = 1'b0;
                bit_count_next  = '0;
                phase_next      = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
                if (s_data.start_req && s_data.op != OP_NONE) begin
                    held_op_next    = s_data.op;
                    held_data_next  = s_data.write_data;
                    shift_next      = load;
                    bit_count_next  = '0;
                    byte_count_next = '0;
                    clock_half_next = 1'b1;
                    phase_next      = PH_ADDR;
                    res.ce_pin      = 1'b1;
                    res.dat_out     = load[0];
                    res.dat_drive   = 1'b1;
                    res.busy_res    = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            clock_half_reg <= 1'b0;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            byte_count_reg <= '0;
            held_op_reg    <= '0;
            held_data_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (acc) begin
                phase_reg      <= phase_next;
                clock_half_reg <= clock_half_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                byte_count_reg <= byte_count_next;
                held_op_reg    <= held_op_next;
                held_data_reg  <= held_data_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            m_data_reg <= res;
        end
    end

    // received byte only inside an active transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_valid |-> m_data.ce_pin && m_data.clk_pin && !m_data.dat_drive)
        else $error("byte beat outside active receive");

    // master drives data only with chip enable high
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dat_drive |-> m_data.ce_pin && m_data.busy_res)
        else $error("data driven without chip enable");

    // closing tick returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc && phase_reg == PH_DONE |=> phase_reg == PH_IDLE && !clock_half_reg)
        else $error("closing tick did not return to idle");

    // a stalled result blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

endmodule
